// ----- hw/rtl/vsb_pkg.sv -----
// shared types and constants of the speech span builder
package vsb_pkg;

  localparam int MS_BITS       = 40;
  localparam int PROB_BITS     = 16;
  localparam int WIN_BITS      = 13;
  localparam int MINLEN_BITS   = 24;
  localparam int PAD_BITS      = 20;
  localparam int RATE_BITS     = 18;
  localparam int CFG_ADDR_BITS = 5;
  localparam int CFG_DATA_BITS = 32;
  localparam int OUT_DATA_BITS = 2 * MS_BITS;

  localparam logic [MS_BITS-1:0]   MS_MAX     = {MS_BITS{1'b1}};
  localparam logic [PROB_BITS:0]   NEG_OFFSET = 17'd9830;

  // register indexes
  localparam logic [2:0] REG_THRESHOLD   = 3'd0;
  localparam logic [2:0] REG_WINDOW      = 3'd1;
  localparam logic [2:0] REG_MIN_SPEECH  = 3'd2;
  localparam logic [2:0] REG_MIN_SILENCE = 3'd3;
  localparam logic [2:0] REG_PAD         = 3'd4;
  localparam logic [2:0] REG_RATE        = 3'd5;

  localparam logic [PROB_BITS-1:0]   RST_THRESHOLD   = 16'd32768;
  localparam logic [WIN_BITS-1:0]    RST_WINDOW      = 13'd512;
  localparam logic [MINLEN_BITS-1:0] RST_MIN_SPEECH  = 24'd4000;
  localparam logic [MINLEN_BITS-1:0] RST_MIN_SILENCE = 24'd1600;
  localparam logic [PAD_BITS-1:0]    RST_PAD         = 20'd480;
  localparam logic [RATE_BITS-1:0]   RST_RATE        = 18'd16000;

  typedef struct packed {
    logic [PROB_BITS-1:0]   speech_threshold;
    logic [WIN_BITS-1:0]    window_samples;
    logic [MINLEN_BITS-1:0] min_speech_samples;
    logic [MINLEN_BITS-1:0] min_silence_samples;
    logic [PAD_BITS-1:0]    pad_samples;
    logic [RATE_BITS-1:0]   rate_hz;
  } vsb_cfg_t;

  typedef struct packed {
    logic busy;
    logic done;
  } vsb_div_sts_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FRAME,
    ST_SIL,
    ST_LEN,
    ST_CONV_S,
    ST_WAIT_S,
    ST_CONV_E,
    ST_WAIT_E,
    ST_MERGE,
    ST_CONV_L,
    ST_WAIT_L,
    ST_FLUSH
  } vsb_state_t;

endpackage

// ----- hw/rtl/vsb_cfg.sv -----
// configuration registers behind the apb-style port
module vsb_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [vsb_pkg::CFG_ADDR_BITS-1:0] cfg_paddr,
  input  logic [vsb_pkg::CFG_DATA_BITS-1:0] cfg_pwdata,
  output logic [vsb_pkg::CFG_DATA_BITS-1:0] cfg_prdata,
  output logic                             cfg_pready,
  output vsb_pkg::vsb_cfg_t                cfg_o
);
  import vsb_pkg::*;

  vsb_cfg_t   cfg_r;
  logic [2:0] reg_idx;
  logic       wr_en;

  assign reg_idx    = cfg_paddr[4:2];
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg_o      = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.speech_threshold    <= RST_THRESHOLD;
      cfg_r.window_samples      <= RST_WINDOW;
      cfg_r.min_speech_samples  <= RST_MIN_SPEECH;
      cfg_r.min_silence_samples <= RST_MIN_SILENCE;
      cfg_r.pad_samples         <= RST_PAD;
      cfg_r.rate_hz             <= RST_RATE;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_THRESHOLD:   cfg_r.speech_threshold    <= cfg_pwdata[PROB_BITS-1:0];
        REG_WINDOW:      cfg_r.window_samples      <= cfg_pwdata[WIN_BITS-1:0];
        REG_MIN_SPEECH:  cfg_r.min_speech_samples  <= cfg_pwdata[MINLEN_BITS-1:0];
        REG_MIN_SILENCE: cfg_r.min_silence_samples <= cfg_pwdata[MINLEN_BITS-1:0];
        REG_PAD:         cfg_r.pad_samples         <= cfg_pwdata[PAD_BITS-1:0];
        REG_RATE:        cfg_r.rate_hz             <= cfg_pwdata[RATE_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_prdata = '0;
    unique case (reg_idx)
      REG_THRESHOLD:   cfg_prdata = CFG_DATA_BITS'(cfg_r.speech_threshold);
      REG_WINDOW:      cfg_prdata = CFG_DATA_BITS'(cfg_r.window_samples);
      REG_MIN_SPEECH:  cfg_prdata = CFG_DATA_BITS'(cfg_r.min_speech_samples);
      REG_MIN_SILENCE: cfg_prdata = CFG_DATA_BITS'(cfg_r.min_silence_samples);
      REG_PAD:         cfg_prdata = CFG_DATA_BITS'(cfg_r.pad_samples);
      REG_RATE:        cfg_prdata = CFG_DATA_BITS'(cfg_r.rate_hz);
      default:         cfg_prdata = '0;
    endcase
  end

endmodule

// ----- hw/rtl/vsb_div.sv -----
// shared radix-2 divider: samples to milliseconds, saturating
module vsb_div #(
  parameter int SAMPLE_BITS = 41
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [SAMPLE_BITS-1:0]        samples,
  input  logic [vsb_pkg::RATE_BITS-1:0] rate,
  output vsb_pkg::vsb_div_sts_t         sts,
  output logic [vsb_pkg::MS_BITS-1:0]   ms
);
  import vsb_pkg::*;

  localparam int DW = SAMPLE_BITS + 10;
  localparam int CW = $clog2(DW + 1);
  localparam int QW = (DW > MS_BITS) ? DW : MS_BITS + 1;

  logic                 busy_r;
  logic                 prep_r;
  logic                 done_r;
  logic [CW-1:0]        cnt_r;
  logic [DW-1:0]        num_r;
  logic [DW-1:0]        quo_r;
  logic [RATE_BITS-1:0] rate_r;
  logic [RATE_BITS-1:0] rem_r;
  logic [MS_BITS-1:0]   ms_r;

  logic [RATE_BITS:0]   trial;
  logic [RATE_BITS:0]   diff;
  logic                 ge;
  logic [RATE_BITS-1:0] rem_nxt;
  logic [DW-1:0]        quo_nxt;
  logic [QW-1:0]        quo_ext;
  logic [DW-1:0]        times1000;

  // x*1000 = x*1024 - x*32 + x*8
  assign times1000 = {num_r[SAMPLE_BITS-1:0], 10'd0}
                   - {5'd0, num_r[SAMPLE_BITS-1:0], 5'd0}
                   + {7'd0, num_r[SAMPLE_BITS-1:0], 3'd0};

  assign trial   = {rem_r, num_r[DW-1]};
  assign ge      = trial >= {1'b0, rate_r};
  assign diff    = trial - {1'b0, rate_r};
  assign rem_nxt = ge ? diff[RATE_BITS-1:0] : trial[RATE_BITS-1:0];
  assign quo_nxt = {quo_r[DW-2:0], ge};
  assign quo_ext = QW'(quo_nxt);

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign ms       = ms_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      prep_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        prep_r <= 1'b1;
      end else if (prep_r) begin
        prep_r <= 1'b0;
        cnt_r  <= CW'(DW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r  <= DW'(samples);
      rate_r <= (rate == '0) ? RATE_BITS'(1) : rate;
      rem_r  <= '0;
    end else if (prep_r) begin
      num_r <= times1000;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      num_r <= {num_r[DW-2:0], 1'b0};
      quo_r <= quo_nxt;
      if (cnt_r == CW'(1)) begin
        ms_r <= (|quo_ext[QW-1:MS_BITS]) ? MS_MAX : quo_ext[MS_BITS-1:0];
      end
    end
  end

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("divider started while busy");

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r))
    else $error("divider done without a running division");

  a_cnt_live: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && !prep_r) |-> (cnt_r != '0 && cnt_r <= CW'(DW)))
    else $error("divider step count out of range");

endmodule

// ----- hw/rtl/vad_speech_span_builder_top.sv -----
// speech span builder: hysteresis sequencer, shared divider and output register
// a frame without a release passes the frame state and at most the silence and length checks;
//   each ms conversion is done on the shared divider
// a frame that ends a span takes two conversions, a finish up to three
// one item at a time; in_tready is high only while the sequencer waits for work
// results sit in an output register, so the next item is taken while one waits
// synchronous active-low reset clears the speech, silence and held-span flags
module vad_speech_span_builder_top #(
  parameter int POSITION_BITS = 40
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // probability [15:0], position [POSITION_BITS+15:16], zero fill
  input  logic [((vsb_pkg::PROB_BITS+POSITION_BITS+7)/8)*8-1:0] in_tdata,
  // action
  input  logic in_tuser,
  output logic out_tvalid,
  input  logic out_tready,
  // span start in ms [39:0], span end in ms [79:40]
  output logic [vsb_pkg::OUT_DATA_BITS-1:0] out_tdata,
  output logic out_tlast,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [vsb_pkg::CFG_ADDR_BITS-1:0] cfg_paddr,
  input  logic [vsb_pkg::CFG_DATA_BITS-1:0] cfg_pwdata,
  output logic [vsb_pkg::CFG_DATA_BITS-1:0] cfg_prdata,
  output logic                              cfg_pready
);
  import vsb_pkg::*;

  localparam int PB = POSITION_BITS;
  localparam int SW = POSITION_BITS + 1;

  vsb_cfg_t     cfg;
  vsb_div_sts_t div_sts;
  logic [MS_BITS-1:0] div_ms;
  logic               div_start;
  logic [SW-1:0]      div_samples;

  vsb_state_t state_r, state_nxt;

  logic                 act_r;
  logic [PROB_BITS-1:0] prob_r;
  logic [PB-1:0]        pos_r;
  logic                 in_speech_r;
  logic                 sil_pend_r;
  logic                 held_valid_r;
  logic [PB-1:0]        speech_begin_r;
  logic [PB-1:0]        sil_begin_r;
  logic [PB:0]          cursor_r;
  logic [MS_BITS-1:0]   s_ms_r;
  logic [MS_BITS-1:0]   e_ms_r;
  logic [MS_BITS-1:0]   held_start_r;
  logic [MS_BITS-1:0]   held_end_r;
  logic                 out_valid_r;
  logic [MS_BITS-1:0]   out_start_r;
  logic [MS_BITS-1:0]   out_end_r;
  logic                 out_last_r;

  logic               in_accept;
  logic               slot_free;
  logic               prob_high;
  logic               prob_low;
  logic [PB+1:0]      sil_diff;
  logic               sil_ok;
  logic [PB-1:0]      end_sel;
  logic [PB:0]        len_diff;
  logic               len_ok;
  logic               merge_hit;
  logic               merge_emit;
  logic               out_load;
  logic [MS_BITS-1:0] emit_start;
  logic [MS_BITS-1:0] emit_end;
  logic               emit_last;

  vsb_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg_o       (cfg)
  );

  vsb_div #(
    .SAMPLE_BITS (SW)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .samples (div_samples),
    .rate    (cfg.rate_hz),
    .sts     (div_sts),
    .ms      (div_ms)
  );

  assign in_accept = in_tvalid && in_tready;
  assign slot_free = !out_valid_r || out_tready;

  assign prob_high = prob_r >= cfg.speech_threshold;
  assign prob_low  = ({1'b0, prob_r} + NEG_OFFSET) < {1'b0, cfg.speech_threshold};

  assign sil_diff = {1'b0, cursor_r} - {2'b0, sil_begin_r};
  assign sil_ok   = !sil_diff[PB+1] && (sil_diff[PB:0] >= (PB+1)'(cfg.min_silence_samples));

  assign end_sel  = act_r ? pos_r : sil_begin_r;
  assign len_diff = {1'b0, end_sel} - {1'b0, speech_begin_r};
  assign len_ok   = in_speech_r && !len_diff[PB]
                 && (len_diff[PB-1:0] > PB'(cfg.min_speech_samples));

  assign merge_hit  = held_valid_r && (s_ms_r <= held_end_r);
  assign merge_emit = held_valid_r && !merge_hit;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_tvalid) state_nxt = in_tuser ? ST_LEN : ST_FRAME;
      ST_FRAME:  state_nxt = (prob_low && in_speech_r) ? ST_SIL : ST_IDLE;
      ST_SIL:    state_nxt = sil_ok ? ST_LEN : ST_IDLE;
      ST_LEN: begin
        priority if (len_ok)                state_nxt = ST_CONV_S;
        else if (act_r && held_valid_r)     state_nxt = ST_CONV_L;
        else                                state_nxt = ST_IDLE;
      end
      ST_CONV_S: state_nxt = ST_WAIT_S;
      ST_WAIT_S: if (div_sts.done) state_nxt = ST_CONV_E;
      ST_CONV_E: state_nxt = ST_WAIT_E;
      ST_WAIT_E: if (div_sts.done) state_nxt = ST_MERGE;
      ST_MERGE: begin
        if (!merge_emit || slot_free) state_nxt = act_r ? ST_CONV_L : ST_IDLE;
      end
      ST_CONV_L: state_nxt = ST_WAIT_L;
      ST_WAIT_L: if (div_sts.done) state_nxt = ST_FLUSH;
      ST_FLUSH:  if (slot_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_tready   = 1'b0;
    div_start   = 1'b0;
    div_samples = SW'(pos_r);
    out_load    = 1'b0;
    emit_start  = held_start_r;
    emit_end    = held_end_r;
    emit_last   = 1'b1;
    unique case (state_r)
      ST_IDLE: in_tready = 1'b1;
      ST_CONV_S: begin
        div_start   = 1'b1;
        div_samples = (speech_begin_r > PB'(cfg.pad_samples))
                    ? SW'(speech_begin_r - PB'(cfg.pad_samples)) : '0;
      end
      ST_CONV_E: begin
        div_start   = 1'b1;
        div_samples = SW'(end_sel) + SW'(cfg.pad_samples);
      end
      ST_CONV_L: begin
        div_start   = 1'b1;
        div_samples = SW'(pos_r);
      end
      ST_MERGE: begin
        out_load  = merge_emit && slot_free;
        emit_last = !act_r;
      end
      ST_FLUSH: begin
        out_load = slot_free;
        emit_end = (held_end_r > div_ms) ? div_ms : held_end_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      in_speech_r  <= 1'b0;
      sil_pend_r   <= 1'b0;
      held_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_FRAME: begin
          if (prob_high) sil_pend_r <= 1'b0;
          if (prob_high && !in_speech_r) begin
            in_speech_r <= 1'b1;
          end else if (prob_low && in_speech_r && !sil_pend_r) begin
            sil_pend_r <= 1'b1;
          end
        end
        ST_LEN: begin
          if (!act_r) begin
            in_speech_r <= 1'b0;
            sil_pend_r  <= 1'b0;
          end else if (len_ok) begin
            in_speech_r <= 1'b0;
          end
        end
        ST_MERGE: held_valid_r <= 1'b1;
        ST_FLUSH: if (slot_free) held_valid_r <= 1'b0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      act_r  <= in_tuser;
      prob_r <= in_tdata[PROB_BITS-1:0];
      pos_r  <= in_tdata[PROB_BITS +: PB];
    end
    if (out_load) begin
      out_start_r <= emit_start;
      out_end_r   <= emit_end;
      out_last_r  <= emit_last;
    end
    unique case (state_r)
      ST_FRAME: begin
        if (prob_high && !in_speech_r) speech_begin_r <= pos_r;
        if (prob_low && in_speech_r && !sil_pend_r) sil_begin_r <= pos_r;
        cursor_r <= {1'b0, pos_r} + (PB+1)'(cfg.window_samples);
      end
      ST_WAIT_S: if (div_sts.done) s_ms_r <= div_ms;
      ST_WAIT_E: if (div_sts.done) e_ms_r <= div_ms;
      ST_MERGE: begin
        if (merge_hit) begin
          if (e_ms_r > held_end_r) held_end_r <= e_ms_r;
        end else if (!held_valid_r || slot_free) begin
          held_start_r <= s_ms_r;
          held_end_r   <= e_ms_r;
        end
      end
      default: ;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_end_r, out_start_r};
  assign out_tlast  = out_last_r;

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> state_r != ST_IDLE)
    else $error("accepted transfer did not start the sequencer");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_valid_r || out_tready))
    else $error("result register overwritten before its transfer");

  a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FLUSH && out_load) |=> !held_valid_r && state_r == ST_IDLE)
    else $error("held span not cleared after flush");

  a_conv_idle_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CONV_S || state_r == ST_CONV_E || state_r == ST_CONV_L)
      |-> !div_sts.busy)
    else $error("conversion requested while divider busy");

endmodule

// ----- test/vsb_span_checker.sv -----
`timescale 1ns / 100ps
// span checker: watches all channels, predicts speech spans and compares each result transfer
module vsb_span_checker #(
  parameter int POSITION_BITS = 40,
  parameter int IN_BITS       = 56
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  input  logic                                in_tready,
  input  logic [IN_BITS-1:0]                  in_tdata,
  input  logic                                in_tuser,
  input  logic                                out_tvalid,
  input  logic                                out_tready,
  input  logic [vsb_pkg::OUT_DATA_BITS-1:0]   out_tdata,
  input  logic                                out_tlast,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic                                cfg_pready,
  input  logic [vsb_pkg::CFG_ADDR_BITS-1:0]   cfg_paddr,
  input  logic [vsb_pkg::CFG_DATA_BITS-1:0]   cfg_pwdata,
  output int                                  errors,
  output int                                  spans_waiting,
  output int                                  spans_seen
);
  import vsb_pkg::*;

  typedef struct packed {
    logic [MS_BITS-1:0] begin_ms;
    logic [MS_BITS-1:0] end_ms;
    logic               last;
  } span_t;

  localparam logic [63:0] MS_LIMIT = 64'(MS_MAX);

  span_t spans_due[$];

  logic [PROB_BITS-1:0]   speech_threshold;
  logic [WIN_BITS-1:0]    window_samples;
  logic [MINLEN_BITS-1:0] min_speech_samples;
  logic [MINLEN_BITS-1:0] min_silence_samples;
  logic [PAD_BITS-1:0]    pad_samples;
  logic [RATE_BITS-1:0]   rate_hz;

  bit                 talking;
  bit                 quiet_pending;
  bit                 held_valid;
  logic [63:0]        talk_begin;
  logic [63:0]        quiet_begin;
  logic [MS_BITS-1:0] held_start_ms;
  logic [MS_BITS-1:0] held_end_ms;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    errors++;
    if (errors <= 100)
      $display("%0t ns result %0d: %s is %0h, expected %0h", $time, spans_seen, what, got, want);
  endtask

  function automatic logic [MS_BITS-1:0] samples_to_ms(input logic [63:0] samples);
    logic [63:0] rate;
    logic [63:0] whole;
    logic [63:0] rem;
    logic [63:0] ms;
    rate = (rate_hz == '0) ? 64'd1 : 64'(rate_hz);
    whole = samples / rate;
    rem = samples % rate;
    if (whole > MS_LIMIT / 64'd1000) return MS_MAX;
    ms = whole * 64'd1000 + (rem * 64'd1000) / rate;
    return (ms > MS_LIMIT) ? MS_MAX : ms[MS_BITS-1:0];
  endfunction

  // pad and convert a closed span, then merge it into the held span or push the held one out
  function automatic bit close_span(input logic [63:0] first, input logic [63:0] stop,
                                    output span_t gone);
    logic [63:0]        padded;
    logic [MS_BITS-1:0] s_ms;
    logic [MS_BITS-1:0] e_ms;
    padded = (first > 64'(pad_samples)) ? first - 64'(pad_samples) : 64'd0;
    s_ms = samples_to_ms(padded);
    e_ms = samples_to_ms(stop + 64'(pad_samples));
    gone = '{held_start_ms, held_end_ms, 1'b0};
    if (held_valid && s_ms <= held_end_ms) begin
      if (e_ms > held_end_ms) held_end_ms = e_ms;
      return 1'b0;
    end
    close_span = held_valid;
    held_valid = 1'b1;
    held_start_ms = s_ms;
    held_end_ms = e_ms;
  endfunction

  task automatic predict_item(input bit finish, input logic [PROB_BITS-1:0] prob,
                              input logic [63:0] pos);
    span_t              made[$];
    span_t              one;
    logic [63:0]        cursor;
    logic [MS_BITS-1:0] limit_ms;
    bit                 high;
    bit                 low;
    high = prob >= speech_threshold;
    low = (32'(prob) + 32'(NEG_OFFSET)) < 32'(speech_threshold);
    cursor = pos + 64'(window_samples);
    if (!finish) begin
      if (high && quiet_pending) quiet_pending = 1'b0;
      if (high && !talking) begin
        talking = 1'b1;
        talk_begin = pos;
      end else if (low && talking) begin
        if (!quiet_pending) begin
          quiet_pending = 1'b1;
          quiet_begin = pos;
        end
        if (cursor >= quiet_begin && cursor - quiet_begin >= 64'(min_silence_samples)) begin
          if (quiet_begin >= talk_begin &&
              quiet_begin - talk_begin > 64'(min_speech_samples)) begin
            if (close_span(talk_begin, quiet_begin, one)) made = {made, one};
          end
          talking = 1'b0;
          quiet_pending = 1'b0;
        end
      end
    end else begin
      if (talking && pos >= talk_begin && pos - talk_begin > 64'(min_speech_samples)) begin
        if (close_span(talk_begin, pos, one)) made = {made, one};
        talking = 1'b0;
      end
      if (held_valid) begin
        limit_ms = samples_to_ms(pos);
        if (held_end_ms > limit_ms) held_end_ms = limit_ms;
        one = '{held_start_ms, held_end_ms, 1'b0};
        made = {made, one};
        held_valid = 1'b0;
      end
    end
    if (made.size() > 0) made[made.size()-1].last = 1'b1;
    spans_due = {spans_due, made};
  endtask

  task automatic check_span(input span_t got);
    span_t want;
    spans_seen++;
    if (spans_due.size() == 0) begin
      report("unexpected span, start", 64'(got.begin_ms), 64'd0);
      return;
    end
    want = spans_due.pop_front();
    if (got.begin_ms != want.begin_ms)
      report("span start", 64'(got.begin_ms), 64'(want.begin_ms));
    if (got.end_ms != want.end_ms)
      report("span end", 64'(got.end_ms), 64'(want.end_ms));
    if (got.last != want.last)
      report("last", 64'(got.last), 64'(want.last));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      speech_threshold = RST_THRESHOLD;
      window_samples = RST_WINDOW;
      min_speech_samples = RST_MIN_SPEECH;
      min_silence_samples = RST_MIN_SILENCE;
      pad_samples = RST_PAD;
      rate_hz = RST_RATE;
      talking = 1'b0;
      quiet_pending = 1'b0;
      held_valid = 1'b0;
      talk_begin = '0;
      quiet_begin = '0;
      held_start_ms = '0;
      held_end_ms = '0;
      spans_due.delete();
    end else begin
      if (out_tvalid && out_tready)
        check_span('{out_tdata[MS_BITS-1:0], out_tdata[2*MS_BITS-1:MS_BITS], out_tlast});
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[CFG_ADDR_BITS-1:2])
          REG_THRESHOLD:   speech_threshold = cfg_pwdata[PROB_BITS-1:0];
          REG_WINDOW:      window_samples = cfg_pwdata[WIN_BITS-1:0];
          REG_MIN_SPEECH:  min_speech_samples = cfg_pwdata[MINLEN_BITS-1:0];
          REG_MIN_SILENCE: min_silence_samples = cfg_pwdata[MINLEN_BITS-1:0];
          REG_PAD:         pad_samples = cfg_pwdata[PAD_BITS-1:0];
          REG_RATE:        rate_hz = cfg_pwdata[RATE_BITS-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        predict_item(in_tuser, in_tdata[PROB_BITS-1:0],
                     64'(in_tdata[PROB_BITS +: POSITION_BITS]));
    end
    spans_waiting = spans_due.size();
  end

endmodule

// ----- test/vad_speech_span_builder_top_test.sv -----
`timescale 1ns / 100ps
// testbench top of the speech span builder: stimulus, handshake idling and the verdict
module vad_speech_span_builder_top_test;
  import vsb_pkg::*;

  localparam int          POS_BITS      = 40;
  localparam int          IN_BITS       = ((PROB_BITS + POS_BITS + 7) / 8) * 8;
  localparam int          SETTLE_CYCLES = 250;
  localparam int          HOLD_CYCLES   = 1500;
  localparam int          STALL_LIMIT   = 6000;
  localparam logic [63:0] POS_MAX       = 64'hFF_FFFF_FFFF;
  localparam bit          FRAME         = 1'b0;
  localparam bit          FINISH        = 1'b1;

  logic                      clk         = 1'b0;
  logic                      rst_n       = 1'b0;
  logic                      in_tvalid   = 1'b0;
  logic                      in_tready;
  // probability [15:0], position [55:16]
  logic [IN_BITS-1:0]        in_tdata    = '0;
  // action
  logic                      in_tuser    = 1'b0;
  logic                      out_tvalid;
  logic                      out_tready  = 1'b0;
  // span start in ms [39:0], span end in ms [79:40]
  logic [OUT_DATA_BITS-1:0]  out_tdata;
  logic                      out_tlast;
  logic                      cfg_psel    = 1'b0;
  logic                      cfg_penable = 1'b0;
  logic                      cfg_pwrite  = 1'b0;
  logic [CFG_ADDR_BITS-1:0]  cfg_paddr   = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_pwdata  = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_prdata;
  logic                      cfg_pready;

  int errors;
  int spans_waiting;
  int spans_seen;
  int send_idle    = 25;
  int recv_idle    = 49;
  bit hold_req     = 1'b0;
  int hold_left    = 0;
  int stall_cycles = 0;
  int items_sent   = 0;

  logic [PROB_BITS-1:0]   thr_now    = RST_THRESHOLD;
  logic [WIN_BITS-1:0]    win_now    = RST_WINDOW;
  logic [MINLEN_BITS-1:0] minsp_now  = RST_MIN_SPEECH;
  logic [MINLEN_BITS-1:0] minsil_now = RST_MIN_SILENCE;
  logic [63:0]            pos_now    = '0;

  vad_speech_span_builder_top #(.POSITION_BITS(POS_BITS)) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  vsb_span_checker #(.POSITION_BITS(POS_BITS), .IN_BITS(IN_BITS)) u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tlast    (out_tlast),
    .cfg_psel     (cfg_psel),
    .cfg_penable  (cfg_penable),
    .cfg_pwrite   (cfg_pwrite),
    .cfg_pready   (cfg_pready),
    .cfg_paddr    (cfg_paddr),
    .cfg_pwdata   (cfg_pwdata),
    .errors       (errors),
    .spans_waiting(spans_waiting),
    .spans_seen   (spans_seen)
  );

  always #2 clk = ~clk;

  // receiver: random stalls, plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_psel && cfg_penable)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("** vad_speech_span_builder_top: FAILED **");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_item(input bit act, input logic [PROB_BITS-1:0] prob,
                           input logic [63:0] pos);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= act;
    in_tdata <= IN_BITS'({pos[POS_BITS-1:0], prob});
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    while (spans_waiting != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic apb_write(input logic [2:0] idx, input logic [31:0] value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_config(input int unsigned thr, input int unsigned win,
                            input int unsigned msp, input int unsigned msil,
                            input int unsigned pad, input int unsigned rate);
    settle();
    apb_write(REG_THRESHOLD, thr);
    apb_write(REG_WINDOW, win);
    apb_write(REG_MIN_SPEECH, msp);
    apb_write(REG_MIN_SILENCE, msil);
    apb_write(REG_PAD, pad);
    apb_write(REG_RATE, rate);
    thr_now = PROB_BITS'(thr);
    win_now = WIN_BITS'(win);
    minsp_now = MINLEN_BITS'(msp);
    minsil_now = MINLEN_BITS'(msil);
  endtask

  function automatic logic [PROB_BITS-1:0] speech_prob();
    return PROB_BITS'($urandom_range(65535, 32'(thr_now)));
  endfunction

  function automatic logic [PROB_BITS-1:0] quiet_prob();
    if (32'(thr_now) > 32'(NEG_OFFSET))
      return PROB_BITS'($urandom_range(32'(thr_now) - 32'(NEG_OFFSET) - 1, 0));
    return PROB_BITS'($urandom_range(65535, 0));
  endfunction

  // hysteresis band: neither starts nor ends speech, but for a zero threshold, where any value is drawn
  function automatic logic [PROB_BITS-1:0] between_prob();
    int unsigned lo;
    if (thr_now == '0) return PROB_BITS'($urandom_range(65535, 0));
    lo = (32'(thr_now) > 32'(NEG_OFFSET)) ? 32'(thr_now) - 32'(NEG_OFFSET) : 0;
    return PROB_BITS'($urandom_range(32'(thr_now) - 1, lo));
  endfunction

  function automatic logic [63:0] random_pos();
    return 64'({8'($urandom_range(255, 0)), 32'($urandom())});
  endfunction

  task automatic new_recording();
    if ($urandom_range(6) == 0) pos_now = POS_MAX - 64'($urandom_range(300000, 0));
    else pos_now = 64'($urandom_range(1 << 22, 0));
  endtask

  task automatic step_pos();
    int unsigned r;
    r = $urandom_range(39);
    pos_now = pos_now + 64'(win_now);
    if (r == 0) pos_now = pos_now + 64'($urandom_range(3 * 32'(win_now), 0));
    else if (r == 1 && pos_now > 64'(win_now) * 2)
      pos_now = pos_now - 64'($urandom_range(2 * 32'(win_now), 1));
    pos_now = pos_now & POS_MAX;
  endtask

  // speech run of at most 40 frames, mostly long enough to count, then a silence that mostly closes it
  task automatic utterance();
    int unsigned n_speech;
    int unsigned n_quiet;
    int unsigned r;
    n_speech = 32'(minsp_now) / 32'(win_now) + $urandom_range(3, 1);
    if (n_speech > 40) n_speech = $urandom_range(40, 20);
    n_quiet = (32'(minsil_now) + 32'(win_now) - 1) / 32'(win_now) + $urandom_range(2, 1);
    if (n_quiet > 40) n_quiet = $urandom_range(40, 20);
    if ($urandom_range(7) == 0) n_quiet = n_quiet / 2;
    repeat (n_speech) begin
      send_item(FRAME, ($urandom_range(5) == 0) ? between_prob() : speech_prob(), pos_now);
      step_pos();
    end
    repeat (n_quiet) begin
      r = $urandom_range(15);
      send_item(FRAME, (r == 0) ? speech_prob() : (r < 3) ? between_prob() : quiet_prob(),
                pos_now);
      step_pos();
    end
  endtask

  task automatic random_part(input int target, input int span_goal);
    int first_item;
    int first_span;
    int unsigned r;
    first_item = items_sent;
    first_span = spans_seen;
    while ((items_sent - first_item < target || spans_seen - first_span < span_goal) &&
           items_sent - first_item < 4 * target) begin
      r = $urandom_range(99);
      if (r < 68) begin
        utterance();
      end else if (r < 80) begin
        send_item(FINISH, PROB_BITS'($urandom()),
                  pos_now + 64'($urandom_range(4 * 32'(win_now), 0)));
        new_recording();
      end else if (r < 86) begin
        send_item(FINISH, PROB_BITS'($urandom()), random_pos());
        new_recording();
      end else begin
        send_item(FRAME, PROB_BITS'($urandom()), $urandom_range(1) ? random_pos() : pos_now);
      end
    end
  endtask

  initial begin
    int unsigned win;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: thresholds, hysteresis band, merge, flush and clamp
    send_item(FRAME, 16'd0, 64'd0);
    send_item(FINISH, 16'd0, 64'd0);
    send_item(FRAME, 16'd32768, 64'd1000);
    send_item(FRAME, 16'hFFFF, 64'd1512);
    send_item(FRAME, 16'd30000, 64'd2024);
    send_item(FRAME, 16'd22938, 64'd2536);
    send_item(FRAME, 16'd22937, 64'd3048);
    send_item(FRAME, 16'hFFFF, 64'd3560);
    send_item(FRAME, 16'd0, 64'd6000);
    send_item(FRAME, 16'd0, 64'd6512);
    send_item(FRAME, 16'd0, 64'd7024);
    send_item(FRAME, 16'd0, 64'd7536);
    send_item(FRAME, 16'hFFFF, 64'd8000);
    send_item(FRAME, 16'd0, 64'd9000);
    send_item(FRAME, 16'd0, 64'd10600);
    send_item(FRAME, 16'hFFFF, 64'd12000);
    send_item(FRAME, 16'd0, 64'd20000);
    send_item(FRAME, 16'd0, 64'd22000);
    send_item(FRAME, 16'hFFFF, 64'd20500);
    send_item(FRAME, 16'd0, 64'd26000);
    send_item(FRAME, 16'd0, 64'd28000);
    send_item(FRAME, 16'hFFFF, 64'd30000);
    send_item(FINISH, 16'hFFFF, POS_MAX);
    send_item(FRAME, 16'hFFFF, 64'd100);
    send_item(FINISH, 16'd0, 64'd50);
    send_item(FINISH, 16'd0, 64'd3000);
    send_item(FRAME, 16'd0, POS_MAX);
    send_item(FRAME, 16'd0, 64'd5000);
    send_item(FINISH, 16'd0, POS_MAX);

    set_config(0, 4096, 0, 0, 0, 8000);
    new_recording();
    random_part(60, 4);

    set_config(65535, 1, 24'hFFFFFF, 24'hFFFFFF, 20'hFFFFF, 192000);
    new_recording();
    random_part(30, 0);

    for (int ph = 0; ph < 4; ph++) begin
      if (ph == 1) begin
        send_idle = 49;
        recv_idle = 25;
      end
      if (ph == 3) begin
        send_idle = 0;
        recv_idle = 0;
      end
      win = $urandom_range(4096, 64);
      set_config($urandom_range(60000, 12000), win, $urandom_range(6 * win, 0),
                 $urandom_range(4 * win, 0),
                 ($urandom_range(3) == 0) ? $urandom_range(20'hFFFFF, 0)
                                          : $urandom_range(2 * win, 0),
                 $urandom_range(192000, 8000));
      new_recording();
      if (ph == 3) begin
        hold_req = 1'b1;
        random_part(65, 6);
        hold_req = 1'b1;
        random_part(65, 6);
      end else begin
        random_part(110, 10);
      end
    end

    settle();
    if (errors == 0) begin
      $display("** vad_speech_span_builder_top: PASSED **");
    end else begin
      $display("** vad_speech_span_builder_top: FAILED **");
    end
    $finish;
  end

endmodule
